>>> src/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// btlpm_pkg: shared types and constants for the trie prefix-match block
// Actions, status codes and sequencer states.
// ----------------------------------------------------------------------------
package btlpm_pkg;

   localparam int POOL_SIZE_DEF     = 1024;
   localparam int PAYLOAD_WIDTH_DEF = 32;
   localparam int ADDRESS_BITS_DEF  = 32;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_LOOKUP = 3'd1;
   localparam logic [2:0] ACT_EXACT  = 3'd2;
   localparam logic [2:0] ACT_REMOVE = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BAD_LEN = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,   // waiting for a request
      S_WALK,   // node read in flight, one level per cycle
      S_ALLOC,  // creating missing nodes for an insert
      S_FINAL,  // read of target node in flight, apply route change or report exact match
      S_OUT     // result waiting to be taken
   } state_type;

endpackage

>>> src/binary_trie_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match: IPv4 routing table as a binary trie
// Node pool held in one synchronous memory; insert, lookup, exact, remove, clear.
// ----------------------------------------------------------------------------
// One transaction at a time. A request walks the trie one level per cycle,
// root included, each level one read of the node memory. A lookup visits up
// to ADDRESS_BITS + 1 = 33 levels and stops at the first missing child. Exact
// lookup, remove and an insert onto an existing node that reach the prefix
// length go on to S_FINAL, which reads the target node and updates it for
// insert or remove; an insert that creates nodes writes them in S_ALLOC;
// clear, unknown actions and rejected lengths go straight to the result. The
// result is held in an output register until taken and blocks new requests
// meanwhile; once it is taken, the block returns to idle before it accepts
// the next request.
module binary_trie_longest_prefix_match
   #(parameter int POOL_SIZE     = btlpm_pkg::POOL_SIZE_DEF,
     parameter int PAYLOAD_WIDTH = btlpm_pkg::PAYLOAD_WIDTH_DEF)
   (input  logic         clock,
    input  logic         reset,
    input  logic         req_tvalid,
    output logic         req_tready,
    // action[2:0], address[34:3], prefix_len[40:35], route_payload[72:41], zero fill
    input  logic [79:0]  req_tdata,
    output logic         rsp_tvalid,
    input  logic         rsp_tready,
    // found[0], matched_payload[32:1], matched_network[64:33], matched_len[70:65],
    // status[72:71], nodes_in_use[83:73], zero fill
    output logic [87:0]  rsp_tdata);

   import btlpm_pkg::*;

   localparam int ADDRESS_BITS = ADDRESS_BITS_DEF;
   localparam int IW = $clog2(POOL_SIZE);
   localparam int FW = $clog2(POOL_SIZE + 1);
   localparam int LW = $clog2(ADDRESS_BITS + 1);
   localparam int PW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
   localparam int AW = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;

   typedef struct packed {
      logic [IW-1:0] left;
      logic [IW-1:0] right;
      logic          present;
      logic [PW-1:0] word;
      logic [AW-1:0] network;
      logic [5:0]    length;
   } node_type;

   node_type node_mem [POOL_SIZE];
   node_type rd_q;
   logic          we;
   logic [IW-1:0] wa, ra;
   node_type      wd;

   always_ff @(posedge clock) begin
      if (we) begin
         node_mem[wa] <= wd;
      end
      rd_q <= node_mem[ra];
   end

   state_type state_ff, state_in;
   logic [2:0]    act_ff, act_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [5:0]    len_ff, len_in;
   logic [PW-1:0] pay_ff, pay_in;
   logic [IW-1:0] node_ff, node_in;
   logic [LW-1:0] depth_ff, depth_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          have_ff, have_in;
   logic [PW-1:0] bpay_ff, bpay_in;
   logic [AW-1:0] bnet_ff, bnet_in;
   logic [5:0]    blen_ff, blen_in;
   logic [1:0]    stat_ff, stat_in;
   logic          root_ok_ff, root_ok_in; // root written since reset/clear

   logic [2:0]  r_act;
   logic [31:0] r_addr;
   logic [5:0]  r_len;
   logic [31:0] r_pay;
   assign r_act  = req_tdata[2:0];
   assign r_addr = req_tdata[34:3];
   assign r_len  = req_tdata[40:35];
   assign r_pay  = req_tdata[72:41];

   logic          dir;
   logic [IW-1:0] nxt;
   logic [LW-1:0] target;
   node_type      cur;
   logic [FW:0]   need;

   // root reads as an empty node until it has been written
   always_comb begin
      cur = rd_q;
      if (node_ff == '0 && !root_ok_ff) begin
         cur = '0;
      end
   end

   assign dir    = addr_ff[AW - 1 - depth_ff];
   assign nxt    = dir ? cur.right : cur.left;
   assign target = (act_ff == ACT_LOOKUP) ? LW'(ADDRESS_BITS) : len_ff[LW-1:0];
   assign need   = {1'b0, fill_ff} + (FW+1)'(target - depth_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (r_act == ACT_INSERT || r_act == ACT_LOOKUP || r_act == ACT_EXACT
                   || r_act == ACT_REMOVE) begin
                  if (r_act != ACT_LOOKUP && r_len > 6'(ADDRESS_BITS)) begin
                     state_in = S_OUT;
                  end else begin
                     state_in = S_WALK;
                  end
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_WALK: begin
            if (depth_ff == target || nxt == '0) begin
               if (act_ff == ACT_LOOKUP) begin
                  state_in = S_OUT;
               end else if (depth_ff == target) begin
                  state_in = S_FINAL;
               end else if (act_ff == ACT_INSERT) begin
                  state_in = (need > (FW+1)'(POOL_SIZE)) ? S_OUT : S_ALLOC;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_ALLOC: begin
            if (depth_ff == target) begin
               state_in = S_OUT;
            end
         end
         S_FINAL: state_in = S_OUT;
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      act_in = act_ff; addr_in = addr_ff; len_in = len_ff; pay_in = pay_ff;
      node_in = node_ff; depth_in = depth_ff; fill_in = fill_ff;
      have_in = have_ff; bpay_in = bpay_ff; bnet_in = bnet_ff; blen_in = blen_ff;
      stat_in = stat_ff; root_ok_in = root_ok_ff;
      we = 1'b0; wa = node_ff; wd = cur; ra = node_ff;
      case (state_ff)
         S_IDLE: begin
            ra = '0;
            if (req_tvalid) begin
               act_in = r_act; addr_in = r_addr[AW-1:0]; len_in = r_len;
               pay_in = r_pay[PW-1:0];
               node_in = '0; depth_in = '0; have_in = 1'b0;
               bpay_in = '0; bnet_in = '0; blen_in = '0; stat_in = ST_OK;
               if ((r_act == ACT_INSERT || r_act == ACT_EXACT || r_act == ACT_REMOVE)
                   && r_len > 6'(ADDRESS_BITS)) begin
                  stat_in = ST_BAD_LEN;
               end
               if (r_act == ACT_CLEAR) begin
                  fill_in = FW'(1); root_ok_in = 1'b0;
               end
            end
         end
         S_WALK: begin
            if (act_ff == ACT_LOOKUP && cur.present) begin
               have_in = 1'b1; bpay_in = cur.word; bnet_in = cur.network;
               blen_in = cur.length;
            end
            if (depth_ff == target || nxt == '0) begin
               ra = node_ff;
               if (act_ff == ACT_INSERT && depth_ff != target) begin
                  if (need > (FW+1)'(POOL_SIZE)) begin
                     stat_in = ST_FULL;
                  end else begin
                     // link the first new node into the existing parent
                     we = 1'b1; wa = node_ff; wd = cur;
                     if (dir) wd.right = fill_ff[IW-1:0];
                     else     wd.left  = fill_ff[IW-1:0];
                     if (node_ff == '0) root_ok_in = 1'b1;
                     node_in = fill_ff[IW-1:0];
                     fill_in = fill_ff + FW'(1);
                     depth_in = depth_ff + LW'(1);
                  end
               end
            end else begin
               node_in = nxt; ra = nxt; depth_in = depth_ff + LW'(1);
            end
         end
         S_ALLOC: begin
            we = 1'b1; wa = node_ff; wd = '0;
            if (depth_ff == target) begin
               wd.present = 1'b1; wd.word = pay_ff; wd.network = addr_ff;
               wd.length = len_ff;
            end else begin
               if (dir) wd.right = fill_ff[IW-1:0];
               else     wd.left  = fill_ff[IW-1:0];
               node_in = fill_ff[IW-1:0];
               fill_in = fill_ff + FW'(1);
               depth_in = depth_ff + LW'(1);
            end
         end
         S_FINAL: begin
            wd = cur;
            if (act_ff == ACT_INSERT) begin
               we = 1'b1; wd.present = 1'b1; wd.word = pay_ff;
               wd.network = addr_ff; wd.length = len_ff;
               if (node_ff == '0) root_ok_in = 1'b1;
            end else if (cur.present) begin
               have_in = 1'b1; bpay_in = cur.word; bnet_in = cur.network;
               blen_in = cur.length;
               if (act_ff == ACT_REMOVE) begin
                  we = 1'b1; wd.present = 1'b0;
                  if (node_ff == '0) root_ok_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= FW'(1); root_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; root_ok_ff <= root_ok_in;
      end
      act_ff <= act_in; addr_ff <= addr_in; len_ff <= len_in; pay_ff <= pay_in;
      node_ff <= node_in; depth_ff <= depth_in; have_ff <= have_in;
      bpay_ff <= bpay_in; bnet_ff <= bnet_in; blen_ff <= blen_in; stat_ff <= stat_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {4'd0, 11'(fill_ff), stat_ff, blen_ff, 32'(bnet_ff),
                        32'(bpay_ff), have_ff};

endmodule

>>> dv/btlpm_checker.sv
// ----------------------------------------------------------------------------
// btlpm_checker: route table predictor and result comparator
// Watches both channels, keeps its own trie, compares every response.
// ----------------------------------------------------------------------------
module btlpm_checker
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_tvalid,
    input  logic        req_tready,
    input  logic [79:0] req_tdata,
    input  logic        rsp_tvalid,
    input  logic        rsp_tready,
    input  logic [87:0] rsp_tdata,
    output int          pending,
    output int          mismatches);

   timeunit 1ns;
   timeprecision 1ps;

   import btlpm_pkg::*;

   localparam int NODES = POOL_SIZE_DEF;
   localparam int ABITS = ADDRESS_BITS_DEF;

   typedef struct packed {
      logic [10:0] nodes_in_use;
      logic [1:0]  status;
      logic [5:0]  matched_len;
      logic [31:0] matched_network;
      logic [31:0] matched_payload;
      logic        found;
   } route_result_type;

   logic [9:0]  left_idx  [NODES];
   logic [9:0]  right_idx [NODES];
   logic        has_route [NODES];
   logic [31:0] hop_word  [NODES];
   logic [31:0] net_word  [NODES];
   logic [5:0]  len_word  [NODES];
   int          fill;

   route_result_type expected_routes[$];

   function automatic int next_node(int node, logic dir);
      return dir ? int'(right_idx[node]) : int'(left_idx[node]);
   endfunction

   function automatic void wipe_node(int node);
      left_idx[node] = '0;
      right_idx[node] = '0;
      has_route[node] = 1'b0;
      hop_word[node] = '0;
      net_word[node] = '0;
      len_word[node] = '0;
   endfunction

   function automatic route_result_type hit(int node);
      route_result_type r;
      r = '0;
      r.found = 1'b1;
      r.matched_payload = hop_word[node];
      r.matched_network = net_word[node];
      r.matched_len = len_word[node];
      return r;
   endfunction

   function automatic route_result_type route_step(logic [2:0] act, logic [31:0] addr,
                                                   logic [5:0] plen, logic [31:0] hop);
      route_result_type r;
      int node, depth, nxt, best;
      bit have;
      r = '0;
      node = 0;
      depth = 0;
      case (act)
         ACT_INSERT: begin
            if (plen > ABITS) r.status = ST_BAD_LEN;
            else begin
               while (depth < plen) begin
                  nxt = next_node(node, addr[ABITS-1-depth]);
                  if (nxt == 0) break;
                  node = nxt;
                  depth++;
               end
               if (fill + (plen - depth) > NODES) r.status = ST_FULL;
               else begin
                  for (; depth < plen; depth++) begin
                     wipe_node(fill);
                     if (addr[ABITS-1-depth]) right_idx[node] = fill[9:0];
                     else left_idx[node] = fill[9:0];
                     node = fill;
                     fill++;
                  end
                  has_route[node] = 1'b1;
                  hop_word[node] = hop;
                  net_word[node] = addr;
                  len_word[node] = plen;
               end
            end
         end
         ACT_LOOKUP: begin
            have = has_route[0];
            best = 0;
            for (int i = 0; i < ABITS; i++) begin
               nxt = next_node(node, addr[ABITS-1-i]);
               if (nxt == 0) break;
               node = nxt;
               if (has_route[node]) begin
                  have = 1;
                  best = node;
               end
            end
            if (have) r = hit(best);
         end
         ACT_EXACT, ACT_REMOVE: begin
            if (plen > ABITS) r.status = ST_BAD_LEN;
            else begin
               for (depth = 0; depth < plen; depth++) begin
                  nxt = next_node(node, addr[ABITS-1-depth]);
                  if (nxt == 0) break;
                  node = nxt;
               end
               if (depth == plen && has_route[node]) begin
                  r = hit(node);
                  if (act == ACT_REMOVE) has_route[node] = 1'b0;
               end
            end
         end
         ACT_CLEAR: begin
            wipe_node(0);
            fill = 1;
         end
         default: ;
      endcase
      r.nodes_in_use = fill[10:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   assign pending = expected_routes.size();

   always @(posedge clock) begin
      route_result_type got, want;
      if (reset) begin
         fill = 1;
         wipe_node(0);
         mismatches = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_routes = {expected_routes,
                               route_step(req_tdata[2:0], req_tdata[34:3],
                                          req_tdata[40:35], req_tdata[72:41])};
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[83:0];
            if (expected_routes.size() == 0)
               report_mismatch("unexpected response", 32'd0, 32'd0);
            else begin
               want = expected_routes.pop_front();
               if (got.found !== want.found)
                  report_mismatch("found", 32'(got.found), 32'(want.found));
               if (got.matched_payload !== want.matched_payload)
                  report_mismatch("payload", got.matched_payload, want.matched_payload);
               if (got.matched_network !== want.matched_network)
                  report_mismatch("network", got.matched_network, want.matched_network);
               if (got.matched_len !== want.matched_len)
                  report_mismatch("length", 32'(got.matched_len), 32'(want.matched_len));
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.nodes_in_use !== want.nodes_in_use)
                  report_mismatch("nodes_in_use", 32'(got.nodes_in_use),
                                  32'(want.nodes_in_use));
            end
         end
      end
   end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the trie prefix-match block
// Directed corner requests, then random route table traffic with stalls.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import btlpm_pkg::*;

   localparam int RANDOM_OPS  = 1880;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   int          pending, mismatches;
   int          quiet_cycles = 0;
   int          sent = 0;
   bit          stim_done = 0;
   bit          calm = 0;
   logic [31:0] known_nets[$];
   logic [5:0]  known_lens[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   binary_trie_longest_prefix_match u_top (.*);

   btlpm_checker u_chk (.*);

   task automatic send_op(logic [2:0] act, logic [31:0] addr, logic [5:0] plen,
                          logic [31:0] hop);
      while (!calm && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {7'b0, hop, plen, addr, act};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic random_op();
      logic [31:0] addr, mask;
      logic [5:0]  plen;
      int          pick, k;
      addr = $urandom();
      plen = 6'($urandom_range(32));
      pick = $urandom_range(99);
      // shallow prefixes keep the trie dense; a few long ones drain the pool
      if ($urandom_range(3) != 0) plen = 6'($urandom_range(12));
      if (known_nets.size() > 0 && pick >= 35 && pick < 90) begin
         k = $urandom_range(known_nets.size() - 1);
         addr = known_nets[k];
         plen = known_lens[k];
         if (pick < 60) begin
            mask = (plen == 0) ? 32'h0 : ~32'h0 << (32 - plen);
            send_op(ACT_LOOKUP, (addr & mask) | ($urandom() & ~mask), plen, $urandom());
         end else if (pick < 75) send_op(ACT_EXACT, addr, plen, $urandom());
         else send_op(ACT_REMOVE, addr, plen, $urandom());
      end else if (pick < 35) begin
         send_op(ACT_INSERT, addr, plen, $urandom());
         known_nets = {known_nets, addr};
         known_lens = {known_lens, plen};
      end else if (pick < 96) send_op(ACT_LOOKUP, addr, plen, $urandom());
      else if (pick < 98) send_op(3'($urandom_range(5, 7)), addr, 6'($urandom()), $urandom());
      else if (pick < 99) send_op(3'($urandom_range(0, 3)), addr,
                                  6'($urandom_range(33, 63)), $urandom());
      else begin
         send_op(ACT_CLEAR, addr, 6'($urandom()), $urandom());
         known_nets.delete();
         known_lens.delete();
      end
   endtask

   // receiver with random stalls and long hold-offs while sent is between 301 and 309
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (sent > 300 && sent < 310 && !calm) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_op(ACT_LOOKUP, 32'h0, 6'd0, 32'h0);
      send_op(ACT_INSERT, 32'h0, 6'd0, 32'hFFFF_FFFF);
      send_op(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h1234_5678);
      send_op(ACT_INSERT, 32'hC0A8_0000, 6'd16, 32'hAAAA_5555);
      send_op(ACT_INSERT, 32'hC0A8_0100, 6'd24, 32'h5555_AAAA);
      send_op(ACT_LOOKUP, 32'hC0A8_01FE, 6'd63, 32'h0);
      send_op(ACT_LOOKUP, 32'hC0A8_02FE, 6'd0, 32'h0);
      send_op(ACT_LOOKUP, 32'h0A00_0001, 6'd0, 32'h0);
      send_op(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
      send_op(ACT_EXACT, 32'hC0A8_0000, 6'd16, 32'h0);
      send_op(ACT_EXACT, 32'hC0A8_0000, 6'd17, 32'h0);
      send_op(ACT_EXACT, 32'hC0A8_0000, 6'd40, 32'h0);
      send_op(ACT_INSERT, 32'h0, 6'd33, 32'h1);
      send_op(ACT_REMOVE, 32'hC0A8_0100, 6'd24, 32'h0);
      send_op(ACT_REMOVE, 32'hC0A8_0100, 6'd24, 32'h0);
      send_op(ACT_REMOVE, 32'h0, 6'd63, 32'h0);
      send_op(ACT_LOOKUP, 32'hC0A8_01FE, 6'd0, 32'h0);
      send_op(ACT_INSERT, 32'hC0A8_0100, 6'd24, 32'h0BAD_F00D);
      send_op(ACT_LOOKUP, 32'hC0A8_01FE, 6'd0, 32'h0);
      send_op(3'd5, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
      send_op(3'd7, 32'h0, 6'd0, 32'h0);
      send_op(ACT_CLEAR, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
      send_op(ACT_LOOKUP, 32'hC0A8_01FE, 6'd0, 32'h0);
      // fill the pool with disjoint 32-bit routes until inserts report full
      for (int i = 0; i < 40; i++)
         send_op(ACT_INSERT, {i[5:0], 26'($urandom())}, 6'd32, $urandom());
      send_op(ACT_CLEAR, 32'h0, 6'd0, 32'h0);
      for (int i = 0; i < RANDOM_OPS; i++) begin
         calm = (i >= 900 && i < 1100);
         random_op();
      end
      req_tvalid <= 1'b0;
      calm = 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
